// ----- sv/rti_pkg.sv -----
// Package for the RGB to I420 (BT.601) converter.
// Holds the shared field widths, color coefficients and the line store entry type.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rti_pkg;

    // Width of the size and mode registers on the configuration port.
    localparam int CFG_W = 12;

    // Studio-range BT.601 coefficients.
    localparam logic signed [9:0] STUDIO_YR = 10'sd66;
    localparam logic signed [9:0] STUDIO_YG = 10'sd129;
    localparam logic signed [9:0] STUDIO_YB = 10'sd25;
    localparam logic signed [9:0] STUDIO_UR = -10'sd38;
    localparam logic signed [9:0] STUDIO_UG = -10'sd74;
    localparam logic signed [9:0] STUDIO_UB = 10'sd112;
    localparam logic signed [9:0] STUDIO_VR = 10'sd56;
    localparam logic signed [9:0] STUDIO_VG = -10'sd47;
    localparam logic signed [9:0] STUDIO_VB = -10'sd9;

    // Full-range coefficients.
    localparam logic signed [9:0] FULL_YR = 10'sd77;
    localparam logic signed [9:0] FULL_YG = 10'sd150;
    localparam logic signed [9:0] FULL_YB = 10'sd29;
    localparam logic signed [9:0] FULL_UR = -10'sd43;
    localparam logic signed [9:0] FULL_UG = -10'sd84;
    localparam logic signed [9:0] FULL_UB = 10'sd127;
    localparam logic signed [9:0] FULL_VR = 10'sd127;
    localparam logic signed [9:0] FULL_VG = -10'sd106;
    localparam logic signed [9:0] FULL_VB = -10'sd21;

    localparam logic signed [19:0] ROUND_8  = 20'sd128;
    localparam logic signed [19:0] ROUND_7  = 20'sd64;
    localparam logic [7:0]         LUMA_OFS = 8'd16;
    localparam logic signed [10:0] CHROMA_OFS = 11'sd128;

    // Per-pixel color components.
    typedef struct packed {
        logic        [7:0] luma;
        logic signed [7:0] u;
        logic signed [7:0] v;
    } t_yuv;

    // One line store entry: horizontal pair sums of U and V.
    typedef struct packed {
        logic signed [9:0] v;
        logic signed [9:0] u;
    } t_pair_sum;

endpackage

`default_nettype wire

// ----- sv/rti_color.sv -----
// Per-pixel RGB to Y/U/V conversion with constant coefficients.
// Combinational; depends on rti_pkg for coefficients and the t_yuv type.
`timescale 1ns / 1ps
`default_nettype none

module rti_color (
    input  wire logic        [7:0] i_red,
    input  wire logic        [7:0] i_green,
    input  wire logic        [7:0] i_blue,
    input  wire logic              i_full_range,
    output rti_pkg::t_yuv          o_yuv
);

    logic signed [9:0]  red_s, green_s, blue_s;
    logic signed [9:0]  k_yr, k_yg, k_yb, k_ur, k_ug, k_ub, k_vr, k_vg, k_vb;
    logic signed [19:0] y_sum, u_sum, v_sum;
    logic signed [19:0] y_sh, u_sh, v_sh;

    assign red_s   = signed'({2'b00, i_red});
    assign green_s = signed'({2'b00, i_green});
    assign blue_s  = signed'({2'b00, i_blue});

    always_comb begin
        if (i_full_range) begin
            k_yr = rti_pkg::FULL_YR;
            k_yg = rti_pkg::FULL_YG;
            k_yb = rti_pkg::FULL_YB;
            k_ur = rti_pkg::FULL_UR;
            k_ug = rti_pkg::FULL_UG;
            k_ub = rti_pkg::FULL_UB;
            k_vr = rti_pkg::FULL_VR;
            k_vg = rti_pkg::FULL_VG;
            k_vb = rti_pkg::FULL_VB;
        end else begin
            k_yr = rti_pkg::STUDIO_YR;
            k_yg = rti_pkg::STUDIO_YG;
            k_yb = rti_pkg::STUDIO_YB;
            k_ur = rti_pkg::STUDIO_UR;
            k_ug = rti_pkg::STUDIO_UG;
            k_ub = rti_pkg::STUDIO_UB;
            k_vr = rti_pkg::STUDIO_VR;
            k_vg = rti_pkg::STUDIO_VG;
            k_vb = rti_pkg::STUDIO_VB;
        end
    end

    assign y_sum = red_s * k_yr + green_s * k_yg + blue_s * k_yb + rti_pkg::ROUND_8;
    assign u_sum = red_s * k_ur + green_s * k_ug + blue_s * k_ub + rti_pkg::ROUND_8;
    // Studio V uses a 7-bit shift with matching rounding.
    assign v_sum = red_s * k_vr + green_s * k_vg + blue_s * k_vb +
                   (i_full_range ? rti_pkg::ROUND_8 : rti_pkg::ROUND_7);

    assign y_sh = y_sum >>> 8;
    assign u_sh = u_sum >>> 8;
    assign v_sh = i_full_range ? (v_sum >>> 8) : (v_sum >>> 7);

    always_comb begin
        o_yuv.luma = y_sh[7:0] + (i_full_range ? 8'd0 : rti_pkg::LUMA_OFS);
        o_yuv.u    = u_sh[7:0];
        o_yuv.v    = v_sh[7:0];
    end

endmodule

`default_nettype wire

// ----- sv/rti_line_store.sv -----
// Line store of horizontal chroma pair sums from even rows.
// One write port and one registered read port; depends on rti_pkg for t_pair_sum.
`timescale 1ns / 1ps
`default_nettype none

module rti_line_store #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  wire logic               i_clk,
    input  wire logic               i_wr_en,
    input  wire logic [AW-1:0]      i_wr_addr,
    input  wire rti_pkg::t_pair_sum i_wr_data,
    input  wire logic               i_rd_en,
    input  wire logic [AW-1:0]      i_rd_addr,
    output rti_pkg::t_pair_sum      o_rd_data
);

    rti_pkg::t_pair_sum r_mem [DEPTH];
    rti_pkg::t_pair_sum r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ----- sv/rgba_to_i420_bt601.sv -----
// RGB pixel stream to BT.601 luma plus 4:2:0 chroma: one result per pixel, two-stage pipeline.
// Uses rti_pkg, rti_color and rti_line_store.
//
// A pixel is taken every cycle while the output side keeps up; each result passes through
// the input register, then the result register. The line store is read once, when a pixel
// that completes a 2x2 block is taken, and written once per even-row pixel pair as that
// pair's right pixel leaves the input register. The store has MAX_WIDTH/2 entries and needs
// no clearing after reset. The effective frame size is clamped to 2..MAX and forced even;
// configuration should be written only while the block is idle.
`timescale 1ns / 1ps
`default_nettype none

module rgba_to_i420_bt601 #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_we,
    input  wire logic [1:0]                i_cfg_index,
    input  wire logic [rti_pkg::CFG_W-1:0] i_cfg_data,
    input  wire logic                      i_in_valid,
    output logic                           o_in_stall,
    input  wire logic [7:0]                i_red,
    input  wire logic [7:0]                i_green,
    input  wire logic [7:0]                i_blue,
    output logic                           o_out_valid,
    input  wire logic                      i_out_stall,
    output logic [7:0]                     o_luma,
    output logic                           o_chroma_valid,
    output logic [7:0]                     o_cb,
    output logic [7:0]                     o_cr,
    output logic                           o_end_of_frame
);

    localparam int DEPTH = (MAX_WIDTH / 2 > 1) ? MAX_WIDTH / 2 : 1;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
    localparam int RW    = (MAX_HEIGHT > 2) ? $clog2(MAX_HEIGHT) : 1;
    localparam int XM    = (CW > RW) ? CW : RW;
    localparam int XW    = ((XM > rti_pkg::CFG_W) ? XM : rti_pkg::CFG_W) + 1;

    typedef enum logic [1:0] {
        CFG_IMAGE_WIDTH  = 2'd0,
        CFG_IMAGE_HEIGHT = 2'd1,
        CFG_FULL_RANGE   = 2'd2
    } t_cfg_index;

    // Configuration registers.
    logic [rti_pkg::CFG_W-1:0] r_cfg_width, r_cfg_height;
    logic                      r_full_range;

    // Position of the next pixel.
    logic [CW-1:0] r_col, n_col;
    logic [RW-1:0] r_row, n_row;

    // Input register stage.
    logic          r_s1_valid;
    logic [7:0]    r_red, r_green, r_blue;
    logic          r_s1_odd_col, r_s1_odd_row, r_s1_eof;
    logic [AW-1:0] r_s1_idx;

    // Left pixel of the current horizontal pair.
    logic signed [7:0] r_held_u, r_held_v;

    logic [XW-1:0] w_ext, h_ext, w_eff, h_eff, w_last, h_last, col_ext, row_ext;
    logic [XW-1:0] col_c, row_c;
    logic          last_col, last_row;
    logic          accept, advance;
    logic          rd_en, wr_en;
    logic [AW-1:0] rd_addr;

    rti_pkg::t_yuv      yuv;
    rti_pkg::t_pair_sum wr_data, rd_data;
    logic signed [9:0]  su, sv;
    logic signed [10:0] tu, tv, cb_full, cr_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= rti_pkg::CFG_W'(640);
            r_cfg_height <= rti_pkg::CFG_W'(480);
            r_full_range <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_IMAGE_WIDTH:  r_cfg_width  <= i_cfg_data;
                CFG_IMAGE_HEIGHT: r_cfg_height <= i_cfg_data;
                CFG_FULL_RANGE:   r_full_range <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Effective frame size: clamped to 2..MAX and even.
    always_comb begin
        w_ext = XW'(r_cfg_width);
        h_ext = XW'(r_cfg_height);
        if (w_ext < XW'(2)) begin
            w_eff = XW'(2);
        end else if (w_ext > XW'(MAX_WIDTH)) begin
            w_eff = XW'(MAX_WIDTH);
        end else begin
            w_eff = w_ext;
        end
        if (h_ext < XW'(2)) begin
            h_eff = XW'(2);
        end else if (h_ext > XW'(MAX_HEIGHT)) begin
            h_eff = XW'(MAX_HEIGHT);
        end else begin
            h_eff = h_ext;
        end
        w_eff[0] = 1'b0;
        h_eff[0] = 1'b0;
        w_last   = w_eff - XW'(1);
        h_last   = h_eff - XW'(1);
    end

    // A counter past the last column or row is taken as being on it.
    always_comb begin
        col_ext  = XW'(r_col);
        row_ext  = XW'(r_row);
        col_c    = (col_ext > w_last) ? w_last : col_ext;
        row_c    = (row_ext > h_last) ? h_last : row_ext;
        last_col = (col_c == w_last);
        last_row = (row_c == h_last);
        if (last_col) begin
            n_col = '0;
            n_row = last_row ? '0 : RW'(row_c + XW'(1));
        end else begin
            n_col = CW'(col_c + XW'(1));
            n_row = RW'(row_c);
        end
    end

    assign advance    = r_s1_valid && (!o_out_valid || !i_out_stall);
    assign o_in_stall = r_s1_valid && !advance;
    assign accept     = i_in_valid && !o_in_stall;

    assign rd_addr = AW'(col_c >> 1);
    assign rd_en   = accept && col_c[0] && row_c[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_col      <= n_col;
                r_row      <= n_row;
                r_s1_valid <= 1'b1;
            end else if (advance) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_red        <= i_red;
            r_green      <= i_green;
            r_blue       <= i_blue;
            r_s1_odd_col <= col_c[0];
            r_s1_odd_row <= row_c[0];
            r_s1_eof     <= last_col && last_row;
            r_s1_idx     <= rd_addr;
        end
    end

    rti_color u_color (
        .i_red        (r_red),
        .i_green      (r_green),
        .i_blue       (r_blue),
        .i_full_range (r_full_range),
        .o_yuv        (yuv)
    );

    assign su = 10'(r_held_u) + 10'(yuv.u);
    assign sv = 10'(r_held_v) + 10'(yuv.v);
    assign tu = 11'(su) + 11'(rd_data.u);
    assign tv = 11'(sv) + 11'(rd_data.v);
    assign cb_full = rti_pkg::CHROMA_OFS + (tu >>> 2);
    assign cr_full = rti_pkg::CHROMA_OFS + (tv >>> 2);

    always_comb begin
        wr_data.u = su;
        wr_data.v = sv;
    end
    assign wr_en = advance && r_s1_odd_col && !r_s1_odd_row;

    rti_line_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_line_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_s1_idx),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_u <= '0;
            r_held_v <= '0;
        end else if (advance && !r_s1_odd_col) begin
            r_held_u <= yuv.u;
            r_held_v <= yuv.v;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (advance) begin
            o_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            o_luma         <= yuv.luma;
            o_end_of_frame <= r_s1_eof;
            if (r_s1_odd_col && r_s1_odd_row) begin
                o_chroma_valid <= 1'b1;
                o_cb           <= cb_full[7:0];
                o_cr           <= cr_full[7:0];
            end else begin
                o_chroma_valid <= 1'b0;
                o_cb           <= 8'd0;
                o_cr           <= 8'd0;
            end
        end
    end

    // The store is written only on even rows and read only on odd rows.
    a_no_rw_same_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(wr_en && rd_en))
        else $error("line store read and write in the same cycle");

    // The input side stalls only while the input register holds a pixel.
    a_stall_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_s1_valid)
        else $error("input stalled with an empty input register");

    // The last pixel of a frame always closes a 2x2 block.
    a_eof_has_chroma: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_end_of_frame) |-> o_chroma_valid)
        else $error("end of frame without block chroma");

    // Chroma fields read zero outside block-completing pixels.
    a_chroma_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_chroma_valid) |-> (o_cb == 8'd0 && o_cr == 8'd0))
        else $error("chroma fields nonzero without chroma_valid");

    // A transfer on the input while both stages are full and the output is stalled is impossible.
    a_pipe_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall && r_s1_valid) |-> o_in_stall)
        else $error("pixel taken with both stages full and stalled");

endmodule

`default_nettype wire
